// ----- rtl/qbr_pkg.sv -----
// Shared constants, types and register codes for the quantized bilinear resize block.
`default_nettype none
package qbr_pkg;

    // Plane and arithmetic geometry
    localparam int MAX_WIDTH        = 256;
    localparam int MAX_HEIGHT       = 256;
    localparam int WEIGHT_FRAC_BITS = 11;
    localparam int RATIO_FRAC_BITS  = 16;

    localparam int COORD_W  = 8;                      // pixel coordinate
    localparam int ADDR_W   = 2 * COORD_W;            // plane address {y, x}
    localparam int SIZE_W   = 9;                      // size registers
    localparam int PIX_W    = 8;
    localparam int WEIGHT_W = WEIGHT_FRAC_BITS + 1;   // weight 0..ONE
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << WEIGHT_FRAC_BITS);

    // Coordinate mapping: numerator (2d+1)*in - out, kept non-negative
    localparam int NPROD_W = 2 * SIZE_W;              // (2d+1)*in
    localparam int NUM_W   = NPROD_W - 1;             // below 2^17
    localparam int DIV_W   = NUM_W + WEIGHT_FRAC_BITS; // num << frac bits
    localparam int DEN_W   = SIZE_W + 1;              // 2*out
    localparam int DCNT_W  = $clog2(DIV_W);

    // Blend and scale datapath
    localparam int ROW_W   = PIX_W + WEIGHT_FRAC_BITS;        // one row blend
    localparam int BLEND_W = ROW_W + WEIGHT_FRAC_BITS;        // two-axis blend
    localparam int SCALE_W = 24;
    localparam int PROD_W  = BLEND_W + SCALE_W;
    localparam int SHIFT   = 2 * WEIGHT_FRAC_BITS + RATIO_FRAC_BITS;
    localparam int Q_W     = PROD_W - SHIFT + 1;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_IN_WIDTH    = 3'd0,
        REG_IN_HEIGHT   = 3'd1,
        REG_OUT_WIDTH   = 3'd2,
        REG_OUT_HEIGHT  = 3'd3,
        REG_IN_ZERO     = 3'd4,
        REG_OUT_ZERO    = 3'd5,
        REG_SCALE_RATIO = 3'd6
    } reg_idx_t;

    // Input item kinds carried on tuser
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MAP   = 6'b000010,
        S_DIV   = 6'b000100,
        S_FETCH = 6'b001000,
        S_MAC   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    // Multiply-accumulate control
    typedef struct packed {
        logic en;    // update the accumulator
        logic add;   // add product to accumulator instead of loading it
    } mac_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/qbr_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module qbr_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [qbr_pkg::DIV_W-1:0] dividend,
    input  wire logic [qbr_pkg::DEN_W-1:0] divisor,
    output logic                           done,
    output logic [qbr_pkg::DIV_W-1:0]      quotient
);
    import qbr_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DIV_W-1:0]  dq_reg, dq_next;
    logic [DEN_W:0]    trial;
    logic              fits;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_reg, dq_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        dq_next   = dq_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
            dq_next   = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            dq_next  = {dq_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        dq_reg  <= dq_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule
`default_nettype wire

// ----- rtl/qbr_mac.sv -----
// Shared multiply-accumulate unit for the blend and the requantizing scale.
`default_nettype none
module qbr_mac (
    input  wire logic                        aclk,
    input  wire qbr_pkg::mac_ctrl_t          ctrl,
    input  wire logic [qbr_pkg::BLEND_W-1:0] op_a,
    input  wire logic [qbr_pkg::SCALE_W-1:0] op_b,
    output logic [qbr_pkg::PROD_W-1:0]       acc
);
    import qbr_pkg::*;

    logic [PROD_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(op_a) * PROD_W'(op_b);

    // Load or accumulate the product
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.en) begin
            acc_next = ctrl.add ? acc_reg + prod : prod;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
`default_nettype wire

// ----- rtl/qbr_plane_ram.sv -----
// Source plane store: one write port, one registered read port.
`default_nettype none
module qbr_plane_ram (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [qbr_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [qbr_pkg::PIX_W-1:0]  wr_data,
    input  wire logic                       rd_en,
    input  wire logic [qbr_pkg::ADDR_W-1:0] rd_addr,
    output logic [qbr_pkg::PIX_W-1:0]       rd_data
);
    import qbr_pkg::*;

    logic [PIX_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ----- rtl/quantized_bilinear_resize.sv -----
// Top level: config registers, request sequencer and requantizing datapath.
// A load transfer writes the plane store and the block stays ready for its next item.
// A request transfer runs the sequencer, which takes no new item until the result is
// placed on m_tvalid: the 28-step serial divider runs once per axis, then store reads
// of the four neighbors and the multiply-accumulate steps, then the output step.
// Reset (aresetn low, synchronous) restores the register defaults and idles the
// sequencer; the plane store is not cleared and holds garbage until loaded.
`default_nettype none
module quantized_bilinear_resize (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pos_x[7:0], pos_y[15:8], pixel_in[23:16]
    input  wire logic [0:0]  s_tuser,   // kind[0]
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // pixel_out[7:0]
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import qbr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [SIZE_W-1:0]  in_width_reg, in_height_reg, out_width_reg, out_height_reg;
    logic [PIX_W-1:0]   in_zero_reg, out_zero_reg;
    logic [SCALE_W-1:0] scale_ratio_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = reg_idx_t'(paddr[4:2]);

    // Write the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_width_reg    <= SIZE_W'(2);
            in_height_reg   <= SIZE_W'(2);
            out_width_reg   <= SIZE_W'(1);
            out_height_reg  <= SIZE_W'(1);
            in_zero_reg     <= '0;
            out_zero_reg    <= '0;
            scale_ratio_reg <= SCALE_W'(1 << RATIO_FRAC_BITS);
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_IN_WIDTH:    in_width_reg    <= pwdata[SIZE_W-1:0];
                REG_IN_HEIGHT:   in_height_reg   <= pwdata[SIZE_W-1:0];
                REG_OUT_WIDTH:   out_width_reg   <= pwdata[SIZE_W-1:0];
                REG_OUT_HEIGHT:  out_height_reg  <= pwdata[SIZE_W-1:0];
                REG_IN_ZERO:     in_zero_reg     <= pwdata[PIX_W-1:0];
                REG_OUT_ZERO:    out_zero_reg    <= pwdata[PIX_W-1:0];
                REG_SCALE_RATIO: scale_ratio_reg <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (cfg_sel)
            REG_IN_WIDTH:    prdata = PDATA_W'(in_width_reg);
            REG_IN_HEIGHT:   prdata = PDATA_W'(in_height_reg);
            REG_OUT_WIDTH:   prdata = PDATA_W'(out_width_reg);
            REG_OUT_HEIGHT:  prdata = PDATA_W'(out_height_reg);
            REG_IN_ZERO:     prdata = PDATA_W'(in_zero_reg);
            REG_OUT_ZERO:    prdata = PDATA_W'(out_zero_reg);
            REG_SCALE_RATIO: prdata = PDATA_W'(scale_ratio_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective sizes: inputs clamp to 2..max, outputs of zero act as one
    logic [SIZE_W-1:0] in_w_eff, in_h_eff, out_w_eff, out_h_eff;

    assign in_w_eff  = (in_width_reg < SIZE_W'(2))  ? SIZE_W'(2) :
                       (in_width_reg > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) :
                       in_width_reg;
    assign in_h_eff  = (in_height_reg < SIZE_W'(2)) ? SIZE_W'(2) :
                       (in_height_reg > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) :
                       in_height_reg;
    assign out_w_eff = (out_width_reg == '0)  ? SIZE_W'(1) : out_width_reg;
    assign out_h_eff = (out_height_reg == '0) ? SIZE_W'(1) : out_height_reg;

    // ------------------------------------------------------------------
    // Sequencer and request registers
    state_t              state_reg, state_next;
    logic                axis_reg, axis_next;       // 0: column, 1: row
    logic [2:0]          cnt_reg, cnt_next;         // fetch and MAC step
    logic [COORD_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic [COORD_W-1:0]  idx_x_reg, idx_x_next, idx_y_reg, idx_y_next;
    logic [WEIGHT_W-1:0] w_x_reg, w_x_next, w_y_reg, w_y_next;
    logic [PIX_W-1:0]    pix_reg [4];
    logic [ROW_W-1:0]    r0_reg, r1_reg;
    logic [BLEND_W-1:0]  mag_reg;
    logic                neg_reg;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [PIX_W-1:0]    m_tdata_reg, m_tdata_next;

    logic s_xfer, m_xfer;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid_reg && m_tready;

    // ------------------------------------------------------------------
    // Coordinate mapping for the current axis
    logic [SIZE_W-1:0]  sel_in, sel_out;
    logic [COORD_W-1:0] sel_d;
    logic [SIZE_W-1:0]  odd_d;
    logic [NPROD_W-1:0] num_prod;
    logic               num_neg;
    logic [NUM_W-1:0]   num_pos;
    logic [DIV_W-1:0]   div_dividend;
    logic [DEN_W-1:0]   div_divisor;
    logic               div_start, div_done;
    logic [DIV_W-1:0]   div_quot;
    logic [NUM_W-1:0]   map_sx;
    logic               map_clamp;
    logic [COORD_W-1:0] map_idx;
    logic [WEIGHT_W-1:0] map_w;

    assign sel_in   = axis_reg ? in_h_eff : in_w_eff;
    assign sel_out  = axis_reg ? out_h_eff : out_w_eff;
    assign sel_d    = axis_reg ? py_reg : px_reg;
    assign odd_d    = {sel_d, 1'b1};
    assign num_prod = NPROD_W'(odd_d) * NPROD_W'(sel_in);
    assign num_neg  = num_prod < NPROD_W'(sel_out);
    assign num_pos  = NUM_W'(num_prod - NPROD_W'(sel_out));

    // Negative position maps to index 0, weight 0: divide zero
    assign div_dividend = num_neg ? '0 : {num_pos, {WEIGHT_FRAC_BITS{1'b0}}};
    assign div_divisor  = {sel_out, 1'b0};
    assign div_start    = (state_reg == S_MAP);

    // Quotient holds index above and weight below the binary point
    assign map_sx    = div_quot[DIV_W-1:WEIGHT_FRAC_BITS];
    assign map_clamp = map_sx >= NUM_W'(sel_in - SIZE_W'(1));
    assign map_idx   = map_clamp ? COORD_W'(sel_in - SIZE_W'(2)) : map_sx[COORD_W-1:0];
    assign map_w     = map_clamp ? WEIGHT_ONE : {1'b0, div_quot[WEIGHT_FRAC_BITS-1:0]};

    qbr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ------------------------------------------------------------------
    // Plane store: loads write on the transfer, fetch reads four neighbors
    logic               ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
    logic [PIX_W-1:0]   ram_rd_data;
    logic [COORD_W-1:0] rd_x, rd_y;

    assign ram_wr_en   = s_xfer && (s_tuser[0] == KIND_LOAD);
    assign ram_wr_addr = {s_tdata[15:8], s_tdata[7:0]};
    assign rd_x        = idx_x_reg + COORD_W'(cnt_reg[0]);
    assign rd_y        = idx_y_reg + COORD_W'(cnt_reg[1]);
    assign ram_rd_addr = {rd_y, rd_x};
    assign ram_rd_en   = (state_reg == S_FETCH) && !cnt_reg[2];

    qbr_plane_ram u_plane (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (s_tdata[23:16]),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Multiply-accumulate schedule
    //   step 0/1: row 0 blend, 2/3: row 1 blend, 4/5: vertical blend,
    //   step 6: remove zero point, step 7: scale
    mac_ctrl_t           mac_ctrl;
    logic [BLEND_W-1:0]  mac_a;
    logic [SCALE_W-1:0]  mac_b;
    logic [PROD_W-1:0]   mac_acc;
    logic [WEIGHT_W-1:0] wx0, wy0;
    logic [BLEND_W-1:0]  zterm;
    logic [BLEND_W-1:0]  blend;

    assign wx0   = WEIGHT_ONE - w_x_reg;
    assign wy0   = WEIGHT_ONE - w_y_reg;
    assign zterm = BLEND_W'(in_zero_reg) << (2 * WEIGHT_FRAC_BITS);
    assign blend = mac_acc[BLEND_W-1:0];

    always_comb begin
        mac_ctrl.en  = (state_reg == S_MAC) && (cnt_reg != 3'd6);
        mac_ctrl.add = cnt_reg[0] && (cnt_reg != 3'd7);
        case (cnt_reg)
            3'd0:    begin mac_a = BLEND_W'(pix_reg[0]); mac_b = SCALE_W'(wx0);     end
            3'd1:    begin mac_a = BLEND_W'(pix_reg[1]); mac_b = SCALE_W'(w_x_reg); end
            3'd2:    begin mac_a = BLEND_W'(pix_reg[2]); mac_b = SCALE_W'(wx0);     end
            3'd3:    begin mac_a = BLEND_W'(pix_reg[3]); mac_b = SCALE_W'(w_x_reg); end
            3'd4:    begin mac_a = BLEND_W'(r0_reg);     mac_b = SCALE_W'(wy0);     end
            3'd5:    begin mac_a = BLEND_W'(r1_reg);     mac_b = SCALE_W'(w_y_reg); end
            default: begin mac_a = mag_reg;              mac_b = scale_ratio_reg;   end
        endcase
    end

    qbr_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (mac_acc)
    );

    // ------------------------------------------------------------------
    // Round half away from zero, add output zero point, saturate
    logic [Q_W-1:0] q_mag;
    logic [Q_W:0]   pos_sum;
    logic [PIX_W-1:0] pix_out;

    assign q_mag   = Q_W'(mac_acc[PROD_W-1:SHIFT]) + Q_W'(mac_acc[SHIFT-1]);
    assign pos_sum = (Q_W+1)'(out_zero_reg) + (Q_W+1)'(q_mag);

    always_comb begin
        if (neg_reg) begin
            pix_out = (q_mag > Q_W'(out_zero_reg)) ? '0
                    : PIX_W'(Q_W'(out_zero_reg) - q_mag);
        end else begin
            pix_out = (pos_sum > (Q_W+1)'(255)) ? '1 : pos_sum[PIX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Next-state logic
    always_comb begin
        state_next    = state_reg;
        axis_next     = axis_reg;
        cnt_next      = cnt_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        idx_x_next    = idx_x_reg;
        idx_y_next    = idx_y_reg;
        w_x_next      = w_x_reg;
        w_y_next      = w_y_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_xfer && (s_tuser[0] == KIND_REQUEST)) begin
                    px_next    = s_tdata[7:0];
                    py_next    = s_tdata[15:8];
                    axis_next  = 1'b0;
                    state_next = S_MAP;
                end
            end
            S_MAP: begin
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    if (!axis_reg) begin
                        idx_x_next = map_idx;
                        w_x_next   = map_w;
                        axis_next  = 1'b1;
                        state_next = S_MAP;
                    end else begin
                        idx_y_next = map_idx;
                        w_y_next   = map_w;
                        cnt_next   = '0;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg[2]) begin
                    cnt_next   = '0;
                    state_next = S_MAC;
                end
            end
            S_MAC: begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // Hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pix_out;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            axis_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            axis_reg     <= axis_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        idx_x_reg   <= idx_x_next;
        idx_y_reg   <= idx_y_next;
        w_x_reg     <= w_x_next;
        w_y_reg     <= w_y_next;
        m_tdata_reg <= m_tdata_next;
        // Capture each neighbor in the cycle after its read
        if ((state_reg == S_FETCH) && (cnt_reg != '0)) begin
            pix_reg[2'(cnt_reg - 3'd1)] <= ram_rd_data;
        end
        // Keep the row blends and the zero-point difference
        if ((state_reg == S_MAC) && (cnt_reg == 3'd2)) begin
            r0_reg <= mac_acc[ROW_W-1:0];
        end
        if ((state_reg == S_MAC) && (cnt_reg == 3'd4)) begin
            r1_reg <= mac_acc[ROW_W-1:0];
        end
        if ((state_reg == S_MAC) && (cnt_reg == 3'd6)) begin
            neg_reg <= blend < zterm;
            mag_reg <= (blend < zterm) ? zterm - blend : blend - zterm;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // A new result only follows the output step of a request
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // Mapped weights never exceed one
    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (w_x_reg <= WEIGHT_ONE) && (w_y_reg <= WEIGHT_ONE))
        else $error("interpolation weight above one");

    // Fetched neighbors stay inside the clamped source plane
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |->
            (SIZE_W'(idx_x_reg) <= in_w_eff - SIZE_W'(2)) &&
            (SIZE_W'(idx_y_reg) <= in_h_eff - SIZE_W'(2)))
        else $error("source index beyond plane");

    // The two-axis blend fits its width before the zero point is removed
    a_blend_width: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) && (cnt_reg == 3'd6) |-> (mac_acc[PROD_W-1:BLEND_W] == '0))
        else $error("blend accumulator overflow");
`endif

endmodule
`default_nettype wire
